>>> sv/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/aabb_pkg.sv
// Types and constants for the AABB tree overlap query block.
`timescale 1ns / 1ps
package aabb_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_BOX   = 2'd1;
    localparam logic [1:0] CMD_SEG   = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_TOTAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HITS   = 1'b1;

    localparam int DEFAULT_MAX_NODES = 256;
    localparam logic [8:0] NODE_TOTAL_RST = 9'd0;
    localparam logic [6:0] MAX_HITS_RST   = 7'd64;
    localparam logic [6:0] RESULT_CAP     = 7'd64;

    // shared compare unit widths
    localparam int NUM_W = 34;
    localparam int DEN_W = 33;
    localparam int ACC_W = 70;

    typedef struct packed {
        logic [1:0]         command;
        logic [7:0]         node_index;
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic [8:0]         escape_offset;
        logic               leaf_mark;
    } t_in;

    typedef struct packed {
        logic [7:0] hit_node;
        logic       hit_found;
        logic [6:0] hit_total;
        logic       last;
    } t_out;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic [8:0]         escape;
        logic               leaf;
    } t_node;

    typedef struct packed {
        logic done;
        logic pos;
        logic neg;
    } t_cmp_res;

endpackage

>>> sv/aabb_mem.sv
// Node table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module aabb_mem #(
    parameter int MAX_NODES = aabb_pkg::DEFAULT_MAX_NODES
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [$clog2(MAX_NODES)-1:0] i_wr_addr,
    input  aabb_pkg::t_node              i_wr_data,
    input  logic                         i_rd_en,
    input  logic [$clog2(MAX_NODES)-1:0] i_rd_addr,
    output aabb_pkg::t_node              o_rd_data
);
    import aabb_pkg::*;

    t_node r_mem [MAX_NODES];
    t_node r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

>>> sv/aabb_cmp.sv
// Serial exact sign of a*b - c*d, two multiplier bits per cycle.
`timescale 1ns / 1ps
module aabb_cmp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [aabb_pkg::NUM_W-1:0]   i_a,
    input  logic [aabb_pkg::DEN_W-1:0]          i_b,
    input  logic signed [aabb_pkg::NUM_W-1:0]   i_c,
    input  logic [aabb_pkg::DEN_W-1:0]          i_d,
    output aabb_pkg::t_cmp_res                  o_res
);
    import aabb_pkg::*;

    localparam int STEPS = (DEN_W + 1) / 2;
    localparam int CW = $clog2(STEPS);

    logic signed [NUM_W-1:0] r_a, r_c;
    logic [2*STEPS-1:0]      r_b, r_d;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic [CW-1:0]           r_cnt;
    logic                    r_busy, r_done;

    function automatic logic signed [ACC_W-1:0] mul2(input logic signed [NUM_W-1:0] a,
                                                     input logic [1:0] m);
        logic signed [ACC_W-1:0] e;
        e = {{(ACC_W-NUM_W){a[NUM_W-1]}}, a};
        case (m)
            2'd0:    mul2 = '0;
            2'd1:    mul2 = e;
            2'd2:    mul2 = e <<< 1;
            default: mul2 = e + (e <<< 1);
        endcase
    endfunction

    always_comb begin
        n_acc = (r_acc <<< 2) + mul2(r_a, r_b[2*STEPS-1 -: 2]) - mul2(r_c, r_d[2*STEPS-1 -: 2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
        if (i_start) begin
            r_a   <= i_a;
            r_c   <= i_c;
            r_b   <= (2*STEPS)'(i_b);
            r_d   <= (2*STEPS)'(i_d);
            r_acc <= '0;
            r_cnt <= CW'(STEPS - 1);
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= r_b << 2;
            r_d   <= r_d << 2;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_res.done = r_done;
    assign o_res.pos  = !r_acc[ACC_W-1] && (r_acc != '0);
    assign o_res.neg  = r_acc[ACC_W-1];

endmodule

>>> sv/aabb_tree_overlap_query.sv
// Top level: stackless overlap walk over a 2D bounding-box tree table.
//
// Input channel (i_in_valid / o_in_stall, payload i_in_data): command 0 writes
// one node into the table in the transfer cycle; command 1 runs a box query and
// command 2 a segment query; command 3 is dropped. A query holds o_in_stall
// high until its final result has been loaded into the output register.
// Output channel (o_out_valid / i_out_stall, payload o_out_data): one transfer
// per reported leaf in walk order, the final one marked last; a query with no
// reported leaf gives one empty result with last set.
// Config channel (i_cfg_valid / o_cfg_ready): always ready; index 0 is
// node_total, index 1 is max_hits.
// Walk: each visited node costs a table read plus the test; a segment test runs
// up to three exact slab compares per axis on the shared serial compare unit.
// Output stall holds the walk only when a new result must be loaded.
// Reset clears the sequencer and the output valid, and sets node_total to 0 and
// max_hits to 64; the node table is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module aabb_tree_overlap_query #(
    parameter int MAX_NODES = aabb_pkg::DEFAULT_MAX_NODES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  aabb_pkg::t_in                      i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output aabb_pkg::t_out                     o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [aabb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [aabb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import aabb_pkg::*;

    localparam int IW = $clog2(MAX_NODES);
    localparam int WW = $clog2(MAX_NODES + 512);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_TEST = 4'd2;
    localparam logic [3:0] S_AX   = 4'd3;
    localparam logic [3:0] S_C1   = 4'd4;
    localparam logic [3:0] S_C2   = 4'd5;
    localparam logic [3:0] S_C3   = 4'd6;
    localparam logic [3:0] S_ADV  = 4'd7;
    localparam logic [3:0] S_END  = 4'd8;

    logic [3:0]     r_state;
    logic [8:0]     r_node_total;
    logic [6:0]     r_max_hits;
    logic [WW-1:0]  r_total, r_idx;
    logic [6:0]     r_cap, r_count;
    logic           r_seg;
    logic signed [31:0] r_qx0, r_qy0, r_qx1, r_qy1;
    logic           r_hit, r_ax, r_go;
    logic signed [NUM_W-1:0] r_n1, r_n2, r_lo_n, r_hi_n;
    logic [DEN_W-1:0]        r_den, r_lo_d, r_hi_d;
    logic           r_pend;
    logic [7:0]     r_pend_node;
    logic [6:0]     r_pend_total;
    logic           r_o_valid;
    t_out           r_out;

    t_node          w_node;
    t_cmp_res       w_res;
    logic           w_start;
    logic signed [NUM_W-1:0] w_a, w_c;
    logic [DEN_W-1:0]        w_b, w_d;

    logic           in_xfer, slot_free, wr_en;
    logic [WW-1:0]  wr_slot, nt_ext, cfg_total;
    logic [6:0]     cfg_cap;
    logic           box_hit;
    logic signed [31:0] ax_p, ax_e, ax_min, ax_max;
    logic signed [32:0] ax_d, ax_n1, ax_n2;
    logic signed [NUM_W-1:0] ax_s1, ax_s2;
    logic [DEN_W-1:0]        ax_den;
    logic           ax_out;
    logic           emit;
    logic           load_out;
    logic [WW-1:0]  idx_next;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign slot_free   = !r_o_valid || !i_out_stall;
    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_out;

    assign wr_slot = WW'(i_in_data.node_index);
    assign wr_en   = in_xfer && (i_in_data.command == CMD_WRITE) && (wr_slot < WW'(MAX_NODES));
    assign nt_ext    = WW'(r_node_total);
    assign cfg_total = (nt_ext > WW'(MAX_NODES)) ? WW'(MAX_NODES) : nt_ext;
    assign cfg_cap   = (r_max_hits > RESULT_CAP) ? RESULT_CAP : r_max_hits;
    assign load_out  = slot_free && (((r_state == S_ADV) && emit && r_pend) ||
                                     (r_state == S_END));

    aabb_mem #(.MAX_NODES(MAX_NODES)) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_slot[IW-1:0]),
        .i_wr_data ({i_in_data.first_x, i_in_data.first_y, i_in_data.second_x,
                     i_in_data.second_y, i_in_data.escape_offset, i_in_data.leaf_mark}),
        .i_rd_en   (r_state == S_CHK),
        .i_rd_addr (r_idx[IW-1:0]),
        .o_rd_data (w_node)
    );

    always_comb begin
        case (r_state)
            S_C1: begin
                w_a = r_n1;   w_b = r_lo_d; w_c = r_lo_n; w_d = r_den;
            end
            S_C2: begin
                w_a = r_n2;   w_b = r_hi_d; w_c = r_hi_n; w_d = r_den;
            end
            default: begin
                w_a = r_lo_n; w_b = r_hi_d; w_c = r_hi_n; w_d = r_lo_d;
            end
        endcase
        w_start = !r_go && ((r_state == S_C1) || (r_state == S_C2) || (r_state == S_C3));
    end

    aabb_cmp u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_c     (w_c),
        .i_d     (w_d),
        .o_res   (w_res)
    );

    always_comb begin
        box_hit = !(r_qx0 > w_node.max_x || r_qx1 < w_node.min_x ||
                    r_qy0 > w_node.max_y || r_qy1 < w_node.min_y);
        ax_p   = r_ax ? r_qy0 : r_qx0;
        ax_e   = r_ax ? r_qy1 : r_qx1;
        ax_min = r_ax ? w_node.min_y : w_node.min_x;
        ax_max = r_ax ? w_node.max_y : w_node.max_x;
        ax_d   = 33'(ax_e) - 33'(ax_p);
        ax_n1  = 33'(ax_min) - 33'(ax_p);
        ax_n2  = 33'(ax_max) - 33'(ax_p);
        ax_out = (ax_p < ax_min) || (ax_p > ax_max);
        if (ax_d[32]) begin
            ax_s1  = -NUM_W'(ax_n1);
            ax_s2  = -NUM_W'(ax_n2);
            ax_den = DEN_W'(-ax_d);
        end else begin
            ax_s1  = NUM_W'(ax_n1);
            ax_s2  = NUM_W'(ax_n2);
            ax_den = DEN_W'(ax_d);
        end
        emit = w_node.leaf && r_hit && (r_count < r_cap);
        if (r_hit || w_node.leaf) begin
            idx_next = r_idx + 1'b1;
        end else if (w_node.escape == '0) begin
            idx_next = r_idx + 1'b1;
        end else begin
            idx_next = r_idx + WW'(w_node.escape);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_total <= NODE_TOTAL_RST;
            r_max_hits   <= MAX_HITS_RST;
            r_o_valid    <= 1'b0;
            r_go         <= 1'b0;
            r_pend       <= 1'b0;
            r_count      <= '0;
            r_cap        <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_NODE_TOTAL: r_node_total <= i_cfg_data;
                    REG_MAX_HITS:   r_max_hits   <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_out_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer && (i_in_data.command == CMD_BOX ||
                                    i_in_data.command == CMD_SEG)) begin
                        r_seg   <= (i_in_data.command == CMD_SEG);
                        r_qx0   <= i_in_data.first_x;
                        r_qy0   <= i_in_data.first_y;
                        r_qx1   <= i_in_data.second_x;
                        r_qy1   <= i_in_data.second_y;
                        r_total <= cfg_total;
                        r_cap   <= cfg_cap;
                        r_count <= '0;
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_state <= (r_idx < r_total) ? S_TEST : S_END;
                end
                S_TEST: begin
                    if (r_seg) begin
                        r_lo_n  <= '0;
                        r_hi_n  <= NUM_W'(1);
                        r_lo_d  <= DEN_W'(1);
                        r_hi_d  <= DEN_W'(1);
                        r_ax    <= 1'b0;
                        r_state <= S_AX;
                    end else begin
                        r_hit   <= box_hit;
                        r_state <= S_ADV;
                    end
                end
                S_AX: begin
                    if (ax_d == '0) begin
                        if (ax_out) begin
                            r_hit   <= 1'b0;
                            r_state <= S_ADV;
                        end else if (r_ax) begin
                            r_hit   <= 1'b1;
                            r_state <= S_ADV;
                        end else begin
                            r_ax <= 1'b1;
                        end
                    end else begin
                        r_n1    <= (ax_s1 > ax_s2) ? ax_s2 : ax_s1;
                        r_n2    <= (ax_s1 > ax_s2) ? ax_s1 : ax_s2;
                        r_den   <= ax_den;
                        r_state <= S_C1;
                    end
                end
                S_C1: begin
                    if (!r_go) begin
                        r_go <= 1'b1;
                    end else if (w_res.done) begin
                        r_go <= 1'b0;
                        if (w_res.pos) begin
                            r_lo_n <= r_n1;
                            r_lo_d <= r_den;
                        end
                        r_state <= S_C2;
                    end
                end
                S_C2: begin
                    if (!r_go) begin
                        r_go <= 1'b1;
                    end else if (w_res.done) begin
                        r_go <= 1'b0;
                        if (w_res.neg) begin
                            r_hi_n <= r_n2;
                            r_hi_d <= r_den;
                        end
                        r_state <= S_C3;
                    end
                end
                S_C3: begin
                    if (!r_go) begin
                        r_go <= 1'b1;
                    end else if (w_res.done) begin
                        r_go <= 1'b0;
                        if (w_res.pos) begin
                            r_hit   <= 1'b0;
                            r_state <= S_ADV;
                        end else if (r_ax) begin
                            r_hit   <= 1'b1;
                            r_state <= S_ADV;
                        end else begin
                            r_ax    <= 1'b1;
                            r_state <= S_AX;
                        end
                    end
                end
                S_ADV: begin
                    if (!emit) begin
                        r_idx   <= idx_next;
                        r_state <= S_CHK;
                    end else if (!r_pend || slot_free) begin
                        if (r_pend) begin
                            r_out.hit_node  <= r_pend_node;
                            r_out.hit_found <= 1'b1;
                            r_out.hit_total <= r_pend_total;
                            r_out.last      <= 1'b0;
                        end
                        r_pend       <= 1'b1;
                        r_pend_node  <= r_idx[7:0];
                        r_pend_total <= r_count + 1'b1;
                        r_count      <= r_count + 1'b1;
                        r_idx        <= idx_next;
                        r_state      <= S_CHK;
                    end
                end
                S_END: begin
                    if (slot_free) begin
                        r_out.hit_node  <= r_pend ? r_pend_node : 8'd0;
                        r_out.hit_found <= r_pend;
                        r_out.hit_total <= r_pend ? r_pend_total : 7'd0;
                        r_out.last      <= 1'b1;
                        r_pend          <= 1'b0;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_ALWAYS(a_count_cap, i_clk, i_rst_n, r_count <= r_cap)
    `ASSERT_ALWAYS(a_empty_last, i_clk, i_rst_n,
        !(r_o_valid && !r_out.hit_found) || (r_out.last && r_out.hit_total == 7'd0))
    `ASSERT_ALWAYS(a_hit_total, i_clk, i_rst_n,
        !(r_o_valid && r_out.hit_found) || (r_out.hit_total != 7'd0))
    `ASSERT_NEXT(a_end_idle, i_clk, i_rst_n, r_state == S_END && slot_free,
        r_o_valid && r_out.last && !o_in_stall)

endmodule
